// ===== rtl/uer_pkg.sv =====
package uer_pkg;

  localparam int unsigned TRIG_W = 16;
  localparam int unsigned LIMIT_W = 19;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned DIST_W = 17;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_SHIFT = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [TRIG_W-1:0] TRIG_RESET = 16'd176;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 19'd393216;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd17983;

  typedef enum logic [1:0] {
    REG_TRIGGER_TICKS = 2'd0,
    REG_MAX_TICKS     = 2'd1,
    REG_CM_SCALE      = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } phase_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_ticks;
    logic [LIMIT_W-1:0] max_ticks;
    logic [SCALE_W-1:0] cm_scale;
  } cfg_t;

  typedef struct packed {
    logic trigger_out;
    logic busy_res;
    logic done_res;
    logic timed_out;
    logic dist_en;
  } stage_flags_t;

endpackage

// ===== rtl/uer_if.sv =====
interface uer_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_result_if;
  logic        valid;
  logic        ready;
  logic        trigger_out;
  logic        busy_res;
  logic        done_res;
  logic [16:0] distance_q8;
  logic        timed_out;

  modport source (
    output valid, output trigger_out, output busy_res, output done_res,
    output distance_q8, output timed_out, input ready
  );
  modport sink (
    input valid, input trigger_out, input busy_res, input done_res,
    input distance_q8, input timed_out, output ready
  );
endinterface

// ===== rtl/uer_regs.sv =====
module uer_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output uer_pkg::cfg_t              cfg
);
  import uer_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks <= TRIG_RESET;
      cfg.max_ticks <= LIMIT_RESET;
      cfg.cm_scale <= SCALE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_TRIGGER_TICKS: cfg.trigger_ticks <= pwdata[TRIG_W-1:0];
        REG_MAX_TICKS:     cfg.max_ticks <= pwdata[LIMIT_W-1:0];
        REG_CM_SCALE:      cfg.cm_scale <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRIGGER_TICKS: prdata = DATA_W'(cfg.trigger_ticks);
      REG_MAX_TICKS:     prdata = DATA_W'(cfg.max_ticks);
      REG_CM_SCALE:      prdata = DATA_W'(cfg.cm_scale);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== rtl/uer_ctrl.sv =====
module uer_ctrl #(
  parameter int unsigned COUNT_BITS = 19
) (
  input  logic                    clk,
  input  logic                    rst,
  input  uer_pkg::cfg_t           cfg,
  input  logic                    advance,
  uer_tick_if.sink                tick,
  output logic                    stage_valid,
  output uer_pkg::stage_flags_t   stage_flags,
  output logic [COUNT_BITS-1:0]   stage_count
);
  import uer_pkg::*;

  localparam int unsigned CW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [COUNT_BITS-1:0] bumped;
  logic                  accept;
  logic                  trig_lt;
  logic                  lim_bumped, lim_one;
  stage_flags_t          flags;

  assign tick.ready = advance;
  assign accept = tick.valid && advance;

  assign bumped = (tick_count == COUNT_MAX) ? tick_count : tick_count + COUNT_ONE;
  assign trig_lt = CW'(tick_count) < CW'(cfg.trigger_ticks);
  assign lim_bumped = (CW'(bumped) >= CW'(cfg.max_ticks)) || (bumped == COUNT_MAX);
  assign lim_one = CW'(COUNT_ONE) >= CW'(cfg.max_ticks);

  always_comb begin
    phase_next = phase;
    tick_count_next = tick_count;
    flags = '0;
    unique case (phase)
      PH_IDLE: begin
        if (tick.start_req) begin
          phase_next = PH_TRIG;
          tick_count_next = COUNT_ONE;
          flags.trigger_out = 1'b1;
        end
      end
      PH_TRIG: begin
        if (trig_lt) begin
          tick_count_next = bumped;
          flags.trigger_out = 1'b1;
        end else begin
          phase_next = PH_WAIT;
          tick_count_next = '0;
        end
      end
      PH_WAIT: begin
        if (tick.echo_level) begin
          phase_next = PH_MEAS;
          tick_count_next = COUNT_ONE;
          if (lim_one) begin
            flags.done_res = 1'b1;
            flags.timed_out = 1'b1;
            flags.dist_en = 1'b1;
          end
        end else begin
          tick_count_next = bumped;
          if (lim_bumped) begin
            flags.done_res = 1'b1;
            flags.timed_out = 1'b1;
          end
        end
      end
      PH_MEAS: begin
        if (tick.echo_level) begin
          tick_count_next = bumped;
          if (lim_bumped) begin
            flags.done_res = 1'b1;
            flags.timed_out = 1'b1;
            flags.dist_en = 1'b1;
          end
        end else begin
          flags.done_res = 1'b1;
          flags.dist_en = 1'b1;
        end
      end
      default: ;
    endcase
    if (flags.done_res) begin
      phase_next = PH_IDLE;
    end
    flags.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tick_count <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase <= phase_next;
        tick_count <= tick_count_next;
      end
      if (advance) begin
        stage_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_flags <= flags;
      stage_count <= tick_count_next;
    end
  end

endmodule

// ===== rtl/uer_dist.sv =====
module uer_dist #(
  parameter int unsigned COUNT_BITS = 19
) (
  input  logic                    clk,
  input  logic                    rst,
  input  uer_pkg::cfg_t           cfg,
  input  logic                    stage_valid,
  input  uer_pkg::stage_flags_t   stage_flags,
  input  logic [COUNT_BITS-1:0]   stage_count,
  output logic                    advance,
  uer_result_if.source            result
);
  import uer_pkg::*;

  localparam int unsigned PW = COUNT_BITS + SCALE_W;
  localparam int unsigned DW = (COUNT_BITS > DIST_W) ? COUNT_BITS : DIST_W;

  logic [PW-1:0]         product;
  logic [COUNT_BITS-1:0] scaled;
  logic [DW-1:0]         scaled_ext;
  logic [DIST_W-1:0]     dist_sat;
  logic                  out_valid;

  assign product = PW'(stage_count) * PW'(cfg.cm_scale);
  assign scaled = product[PW-1:FRAC_SHIFT];
  assign scaled_ext = DW'(scaled);
  assign dist_sat = (scaled_ext > DW'(DIST_MAX)) ? DIST_MAX : scaled_ext[DIST_W-1:0];

  assign advance = !out_valid || result.ready;
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.trigger_out <= stage_flags.trigger_out;
      result.busy_res <= stage_flags.busy_res;
      result.done_res <= stage_flags.done_res;
      result.timed_out <= stage_flags.timed_out;
      result.distance_q8 <= stage_flags.dist_en ? dist_sat : '0;
    end
  end

endmodule

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger: one tick item in, one result item out.
// The accepted tick is registered in the sequencer stage and then in the distance
// multiplier stage on its way to its result item.
// Throughput is one item per cycle; the input stalls only while a result waits.
// Synchronous reset returns the sequencer to idle with a zero count, empties
// both stages and loads the configuration registers with their defaults.
module ultrasonic_echo_ranger #(
  parameter int unsigned COUNT_BITS = 19
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  uer_tick_if.sink                   tick,
  uer_result_if.source               result
);
  import uer_pkg::*;

  cfg_t                  cfg;
  logic                  advance;
  logic                  stage_valid;
  stage_flags_t          stage_flags;
  logic [COUNT_BITS-1:0] stage_count;

  uer_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  uer_ctrl #(.COUNT_BITS(COUNT_BITS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .advance     (advance),
    .tick        (tick),
    .stage_valid (stage_valid),
    .stage_flags (stage_flags),
    .stage_count (stage_count)
  );

  uer_dist #(.COUNT_BITS(COUNT_BITS)) u_dist (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .stage_valid (stage_valid),
    .stage_flags (stage_flags),
    .stage_count (stage_count),
    .advance     (advance),
    .result      (result)
  );

endmodule

// ===== rtl/uer_checker.sv =====
module uer_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        trigger_out,
  input logic        busy_res,
  input logic        done_res,
  input logic [16:0] distance_q8,
  input logic        timed_out
);

  // A finished measurement always leaves the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_timeout_with_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && timed_out |-> done_res)
    else $error("timeout flag without done");

  a_dist_with_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !done_res |-> distance_q8 == 17'd0)
    else $error("distance reported without done");

  a_trigger_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && trigger_out |-> busy_res && !done_res)
    else $error("trigger driven outside a measurement");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(distance_q8))
    else $error("stalled result item changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .trigger_out (result.trigger_out),
  .busy_res    (result.busy_res),
  .done_res    (result.done_res),
  .distance_q8 (result.distance_q8),
  .timed_out   (result.timed_out)
);

// ===== test/ultrasonic_echo_ranger_tb.sv =====
module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  localparam int COUNT_BITS = 19;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS = 800;
  localparam int MAX_GAP = 18;

  typedef struct packed {
    logic              trigger_out;
    logic              busy_res;
    logic              done_res;
    logic [DIST_W-1:0] distance_q8;
    logic              timed_out;
  } echo_reading_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  uer_tick_if   tick_ch ();
  uer_result_if result_ch ();

  ultrasonic_echo_ranger #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .tick(tick_ch),
    .result(result_ch)
  );

  cfg_t                  ranger_cfg;
  phase_t                rng_phase;
  logic [COUNT_BITS-1:0] rng_count;
  echo_reading_t         expected_readings[$];

  bit tx_gaps_on;
  bit rx_gaps_on;
  int rx_hold_cycles;
  int fail_count;
  int n_items;
  int n_results;
  int n_done;
  int n_timeouts;

  function automatic logic [COUNT_BITS-1:0] count_up(logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic bit limit_hit();
    return (rng_count >= ranger_cfg.max_ticks) || (rng_count == '1);
  endfunction

  function automatic logic [DIST_W-1:0] to_distance(logic [COUNT_BITS-1:0] c);
    longint unsigned p;
    p = 64'(c);
    p = (p * ranger_cfg.cm_scale) >> FRAC_SHIFT;
    return (p > DIST_MAX) ? DIST_MAX : p[DIST_W-1:0];
  endfunction

  function automatic echo_reading_t advance_ranger(logic start_bit, logic echo_bit);
    echo_reading_t r;
    r = '0;
    case (rng_phase)
      PH_IDLE: begin
        if (start_bit) begin
          rng_phase = PH_TRIG;
          rng_count = COUNT_BITS'(1);
          r.trigger_out = 1'b1;
        end
      end
      PH_TRIG: begin
        if (rng_count < ranger_cfg.trigger_ticks) begin
          rng_count = count_up(rng_count);
          r.trigger_out = 1'b1;
        end else begin
          rng_phase = PH_WAIT;
          rng_count = '0;
        end
      end
      PH_WAIT: begin
        if (echo_bit) begin
          rng_phase = PH_MEAS;
          rng_count = COUNT_BITS'(1);
          if (limit_hit()) begin
            r.done_res = 1'b1;
            r.timed_out = 1'b1;
            r.distance_q8 = to_distance(rng_count);
          end
        end else begin
          rng_count = count_up(rng_count);
          if (limit_hit()) begin
            r.done_res = 1'b1;
            r.timed_out = 1'b1;
          end
        end
      end
      default: begin
        if (echo_bit) begin
          rng_count = count_up(rng_count);
          if (limit_hit()) begin
            r.done_res = 1'b1;
            r.timed_out = 1'b1;
            r.distance_q8 = to_distance(rng_count);
          end
        end else begin
          r.done_res = 1'b1;
          r.distance_q8 = to_distance(rng_count);
        end
      end
    endcase
    if (r.done_res) rng_phase = PH_IDLE;
    r.busy_res = (rng_phase != PH_IDLE);
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic send_tick(input logic start_bit, input logic echo_bit);
    int gap;
    echo_reading_t want;
    gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.start_req <= start_bit;
    tick_ch.echo_level <= echo_bit;
    do @(posedge clk); while (!tick_ch.ready);
    want = advance_ranger(start_bit, echo_bit);
    expected_readings.push_back(want);
    n_items++;
    if (want.done_res) n_done++;
    if (want.timed_out) n_timeouts++;
  endtask

  task automatic send_run(input logic start_bit, input logic echo_bit, input int count);
    repeat (count) send_tick(start_bit, echo_bit);
  endtask

  // Finish any measurement in flight, then let every result item drain.
  task automatic settle_ranger();
    while (rng_phase != PH_IDLE) send_tick(1'b0, rng_phase == PH_WAIT);
    tick_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_reg(input reg_idx_t idx);
    logic [DATA_W-1:0] want;
    case (idx)
      REG_TRIGGER_TICKS: want = DATA_W'(ranger_cfg.trigger_ticks);
      REG_MAX_TICKS:     want = DATA_W'(ranger_cfg.max_ticks);
      default:           want = DATA_W'(ranger_cfg.cm_scale);
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %s read back, expected %0d, got %0d",
               $time, idx.name(), want, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TRIGGER_TICKS: ranger_cfg.trigger_ticks = value[TRIG_W-1:0];
      REG_MAX_TICKS:     ranger_cfg.max_ticks = value[LIMIT_W-1:0];
      REG_CM_SCALE:      ranger_cfg.cm_scale = value[SCALE_W-1:0];
      default: ;
    endcase
    if (idx != REG_NONE) read_reg(idx);
  endtask

  // Upper bits are filled with noise, since the block must mask them off.
  task automatic set_ranger(input logic [TRIG_W-1:0] trig, input logic [LIMIT_W-1:0] limit,
                            input logic [SCALE_W-1:0] scale);
    write_reg(REG_TRIGGER_TICKS, {16'($urandom), trig});
    write_reg(REG_MAX_TICKS, {13'($urandom), limit});
    write_reg(REG_CM_SCALE, {16'($urandom), scale});
  endtask

  task automatic test_reset_defaults();
    read_reg(REG_TRIGGER_TICKS);
    read_reg(REG_MAX_TICKS);
    read_reg(REG_CM_SCALE);
    send_tick(1'b1, 1'b0);
    send_run(1'b0, 1'b0, TRIG_RESET + 20);
    send_run(1'b0, 1'b1, 40);
    send_tick(1'b0, 1'b0);
    settle_ranger();
  endtask

  task automatic test_special_cases();
    set_ranger(16'd3, 19'd6, 16'h4000);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    // Starts and echo while busy are ignored.
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_run(1'b0, 1'b0, 2);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    // Echo never rises, then echo stays high too long.
    send_tick(1'b1, 1'b0);
    send_run(1'b0, 1'b0, 9);
    send_tick(1'b1, 1'b0);
    send_run(1'b0, 1'b0, 3);
    send_run(1'b0, 1'b1, 7);
    settle_ranger();
    // Zero trigger length and zero limit behave as one.
    set_ranger(16'd0, 19'd0, 16'hFFFF);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_run(1'b0, 1'b0, 2);
    settle_ranger();
    write_reg(REG_NONE, $urandom);
    send_tick(1'b1, 1'b0);
    send_run(1'b0, 1'b1, 2);
    settle_ranger();
  endtask

  task automatic test_config_extremes();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    // Full-width register values read back unchanged.
    set_ranger(16'hFFFF, 19'h7FFFF, 16'hFFFF);
    // A short echo at the widest limit and full scale.
    set_ranger(16'd1, 19'h7FFFF, 16'hFFFF);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_run(1'b0, 1'b1, 40);
    send_tick(1'b0, 1'b0);
    settle_ranger();
    set_ranger(16'd2, 19'd1, 16'd0);
    send_tick(1'b1, 1'b1);
    send_run(1'b0, 1'b0, 4);
    settle_ranger();
    set_ranger(16'd1, 19'd1, 16'hFFFF);
    send_tick(1'b1, 1'b0);
    send_run(1'b0, 1'b1, 3);
    settle_ranger();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_ranger(16'd2, 19'd20, 16'($urandom));
    tx_gaps_on = 1'b0;
    rx_hold_cycles = HOLD_OFF_CYCLES;
    repeat (80) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    settle_ranger();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int first_item;
    int seq;
    logic [SCALE_W-1:0] scale;
    first_item = n_items;
    seq = 0;
    while (n_items - first_item < RANDOM_ITEMS) begin
      if (seq % 8 == 0) begin
        settle_ranger();
        case ($urandom_range(0, 7))
          0:       scale = '0;
          1:       scale = '1;
          default: scale = SCALE_W'($urandom_range(0, 65535));
        endcase
        set_ranger(TRIG_W'($urandom_range(0, 6)),
                   LIMIT_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 30)), scale);
      end
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 12))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (ranger_cfg.trigger_ticks + $urandom_range(0, 1))
          send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, ranger_cfg.max_ticks + 2))
          send_tick($urandom_range(0, 3) == 0, 1'b0);
        repeat ($urandom_range(0, ranger_cfg.max_ticks + 2))
          send_tick($urandom_range(0, 3) == 0, 1'b1);
        send_run(1'b0, 1'b0, $urandom_range(1, 3));
      end
      seq++;
    end
    settle_ranger();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int gap;
    echo_reading_t want;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      n_results++;
      if (expected_readings.size() == 0) begin
        $display("%0t: result item arrived with nothing expected", $time);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        compare_field("trigger_out", want.trigger_out, result_ch.trigger_out);
        compare_field("busy_res", want.busy_res, result_ch.busy_res);
        compare_field("done_res", want.done_res, result_ch.done_res);
        compare_field("distance_q8", want.distance_q8, result_ch.distance_q8);
        compare_field("timed_out", want.timed_out, result_ch.timed_out);
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) || psel || rst)
        stall = 0;
      else
        stall++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.start_req <= 1'b0;
    tick_ch.echo_level <= 1'b0;
    ranger_cfg = '{trigger_ticks: TRIG_RESET, max_ticks: LIMIT_RESET, cm_scale: SCALE_RESET};
    rng_phase = PH_IDLE;
    rng_count = '0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    rx_hold_cycles = 0;
    fail_count = 0;
    n_items = 0;
    n_results = 0;
    n_done = 0;
    n_timeouts = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_special_cases();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    repeat (8) @(posedge clk);
    $display("Sent %0d tick items over reset, corner, extreme, back-pressure and random phases.",
             n_items);
    $display("Checked %0d result items; %0d measurements ended, %0d of them by timeout.",
             n_results, n_done, n_timeouts);
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
